// ----- hdl/lpfr_pkg.sv -----
package lpfr_pkg;

    localparam int MAX_FRAME_LEN = 256;
    localparam int HDR_BYTES     = 4;
    localparam int LEN_W         = 9;
    localparam int ADDR_W        = $clog2(MAX_FRAME_LEN);
    localparam int HDR_CNT_W     = $clog2(HDR_BYTES);
    localparam int TICK_W        = 16;

    typedef enum logic [1:0] {
        MODE_BYTE    = 2'd0,
        MODE_TICK    = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_READ    = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        PH_LENGTH  = 4'b0001,
        PH_ID      = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_HELD    = 4'b1000
    } phase_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic             byte_taken;
        logic             frame_ready;
        logic [7:0]       frame_id;
        logic [LEN_W-1:0] frame_length;
        logic [7:0]       read_data;
        logic             length_rejected;
        logic             timed_out;
    } out_item_t;

endpackage

// ----- hdl/length_prefixed_frame_receiver.sv -----
// Channel   Handshake              Payload
// in        in_valid / in_stall    in_item  (mode, rx_byte, read_index)
// out       out_valid / out_stall  out_item (one result per input item)
// cfg       cfg_valid / cfg_ready  cfg_data (timeout_limit)
//
// One item per cycle sustained while out_stall is low; an item passes the input register, then
// state update, payload buffer write/read and result register in one pass.
// The payload buffer is a 256x8 memory with one write and one registered read.
// Reset clears the framing state, tick counter and timeout limit; buffer is
// left as is. out_stall holds the result register and backs up into in_stall.
module length_prefixed_frame_receiver (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  lpfr_pkg::in_item_t    in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output lpfr_pkg::out_item_t   out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [15:0]           cfg_data
);
    import lpfr_pkg::*;

    logic                 in_valid_reg;
    in_item_t             in_item_reg;
    logic                 out_valid_reg;
    out_item_t            out_item_reg;
    logic [7:0]           rd_data_reg;
    logic                 rd_sel_reg;
    logic [TICK_W-1:0]    limit_reg;

    phase_t               phase_reg, phase_next;
    logic [HDR_CNT_W-1:0] hdr_reg, hdr_next;
    logic [23:0]          shift_reg, shift_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [7:0]           id_reg, id_next;
    logic [LEN_W-1:0]     pos_reg, pos_next;
    logic [TICK_W-1:0]    elapsed_reg, elapsed_next;
    logic                 rd_sel_next;

    logic [7:0]           mem [MAX_FRAME_LEN];

    logic                 out_load;
    logic                 tout;
    logic                 taken;
    logic                 rejected;
    logic                 wr_en;
    logic [31:0]          hdr_full;
    logic [LEN_W-1:0]     pos_inc;
    logic [LEN_W-1:0]     rd_idx_ext;
    out_item_t            res;

    assign cfg_ready = 1'b1;
    assign out_load  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        out_item           = out_item_reg;
        out_item.read_data = rd_sel_reg ? rd_data_reg : 8'd0;
    end

    always_comb
    begin
        tout         = elapsed_reg > limit_reg;
        phase_next   = tout ? PH_LENGTH : phase_reg;
        hdr_next     = tout ? '0 : hdr_reg;
        elapsed_next = tout ? '0 : elapsed_reg;
        shift_next   = shift_reg;
        len_next     = len_reg;
        id_next      = id_reg;
        pos_next     = pos_reg;
        taken        = 1'b0;
        rejected     = 1'b0;
        wr_en        = 1'b0;
        rd_sel_next  = 1'b0;
        hdr_full     = {shift_reg, in_item_reg.rx_byte};
        pos_inc      = pos_reg + LEN_W'(1);
        rd_idx_ext   = LEN_W'(in_item_reg.read_index);

        unique case (in_item_reg.mode)
            MODE_BYTE:
            begin
                unique case (phase_next)
                    PH_LENGTH:
                    begin
                        taken      = 1'b1;
                        shift_next = {shift_reg[15:0], in_item_reg.rx_byte};
                        if (hdr_next == HDR_CNT_W'(HDR_BYTES - 1))
                        begin
                            hdr_next = '0;
                            if (hdr_full >= 32'd1 && hdr_full <= 32'(MAX_FRAME_LEN))
                            begin
                                phase_next = PH_ID;
                                len_next   = hdr_full[LEN_W-1:0];
                            end
                            else
                            begin
                                rejected = 1'b1;
                            end
                        end
                        else
                        begin
                            hdr_next = hdr_next + HDR_CNT_W'(1);
                        end
                    end
                    PH_ID:
                    begin
                        taken      = 1'b1;
                        id_next    = in_item_reg.rx_byte;
                        pos_next   = LEN_W'(1);
                        phase_next = (len_reg == LEN_W'(1)) ? PH_HELD : PH_PAYLOAD;
                    end
                    PH_PAYLOAD:
                    begin
                        taken    = 1'b1;
                        wr_en    = pos_reg < LEN_W'(MAX_FRAME_LEN);
                        pos_next = pos_inc;
                        if (pos_inc >= len_reg)
                            phase_next = PH_HELD;
                    end
                    default:
                    begin
                        taken = 1'b0;
                    end
                endcase
            end
            MODE_TICK:
            begin
                if (phase_next != PH_HELD && elapsed_next != '1)
                    elapsed_next = elapsed_next + TICK_W'(1);
            end
            MODE_RELEASE:
            begin
                phase_next   = PH_LENGTH;
                hdr_next     = '0;
                elapsed_next = '0;
            end
            default:
            begin
                rd_sel_next = rd_idx_ext < LEN_W'(MAX_FRAME_LEN);
            end
        endcase

        if (phase_next == PH_HELD)
            elapsed_next = '0;

        res.byte_taken      = taken;
        res.frame_ready     = phase_next == PH_HELD;
        res.frame_id        = (phase_next == PH_PAYLOAD || phase_next == PH_HELD)
                              ? id_next : 8'd0;
        res.frame_length    = (phase_next != PH_LENGTH) ? len_next : '0;
        res.read_data       = 8'd0;
        res.length_rejected = rejected;
        res.timed_out       = tout;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_sel_reg    <= 1'b0;
            limit_reg     <= '0;
            phase_reg     <= PH_LENGTH;
            hdr_reg       <= '0;
            shift_reg     <= '0;
            len_reg       <= '0;
            id_reg        <= '0;
            pos_reg       <= '0;
            elapsed_reg   <= '0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                rd_sel_reg    <= rd_sel_next;
                phase_reg     <= phase_next;
                hdr_reg       <= hdr_next;
                shift_reg     <= shift_next;
                len_reg       <= len_next;
                id_reg        <= id_next;
                pos_reg       <= pos_next;
                elapsed_reg   <= elapsed_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers and buffer: no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_item;
        if (out_load)
        begin
            out_item_reg <= res;
            rd_data_reg  <= mem[in_item_reg.read_index[ADDR_W-1:0]];
            if (wr_en)
                mem[pos_reg[ADDR_W-1:0]] <= in_item_reg.rx_byte;
        end
    end

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("phase register not one-hot");

    a_held_no_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HELD |-> elapsed_reg == '0)
        else $error("tick count nonzero while frame held");

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> (pos_reg < len_reg && pos_reg != '0))
        else $error("payload position outside frame");

    a_held_refuses: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && in_item_reg.mode == MODE_BYTE && phase_reg == PH_HELD
         && elapsed_reg <= limit_reg) |=> !out_item_reg.byte_taken)
        else $error("byte taken while frame held");

    a_ready_has_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.frame_ready) |-> out_item_reg.frame_length != '0)
        else $error("held frame with zero length");

endmodule

// ----- dv/length_prefixed_frame_receiver_tb.sv -----
module length_prefixed_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpfr_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PLAN_ROWS     = 26;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 210;
    localparam int DRAIN_CYCLES  = 4;

    localparam out_item_t OUT_QUIET    = '0;
    localparam out_item_t OUT_TAKEN    = '{byte_taken: 1'b1, default: '0};
    localparam out_item_t OUT_TIMEOUT  = '{byte_taken: 1'b1, timed_out: 1'b1, default: '0};
    localparam out_item_t OUT_REJECTED = '{byte_taken: 1'b1, length_rejected: 1'b1,
                                           default: '0};

    typedef struct {
        bit          is_cfg;
        logic [15:0] cfg_value;
        in_item_t    item;
        bit          has_exp;
        out_item_t   exp;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // shadow of the receiver
    phase_t      rx_phase;
    logic [1:0]  hdr_count;
    logic [31:0] len_word;
    logic [7:0]  id_byte;
    logic [8:0]  wr_pos;
    logic [15:0] tick_count;
    logic [15:0] limit_reg;
    logic [7:0]  frame_buf [MAX_FRAME_LEN];
    bit          buf_written [MAX_FRAME_LEN];
    int          written_idx [$];

    out_item_t   predicted_results [$];
    in_item_t    burst_q [$];
    plan_row_t   directed_plan [PLAN_ROWS];
    logic [15:0] phase_limits [RANDOM_PHASES];

    int          mismatch_count;
    int          cycle_count;
    int          idle_pct;
    int          stall_pct;

    length_prefixed_frame_receiver u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("length_prefixed_frame_receiver_tb: errors");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic out_item_t advance_receiver(in_item_t it);
        out_item_t r;
        r = '0;
        if (tick_count > limit_reg)
        begin
            rx_phase   = PH_LENGTH;
            hdr_count  = '0;
            tick_count = '0;
            r.timed_out = 1'b1;
        end
        case (it.mode)
            MODE_BYTE:
            begin
                r.byte_taken = 1'b1;
                case (rx_phase)
                    PH_LENGTH:
                    begin
                        len_word = {len_word[23:0], it.rx_byte};
                        if (hdr_count == 2'd3)
                        begin
                            hdr_count = '0;
                            if (len_word >= 1 && len_word <= MAX_FRAME_LEN)
                                rx_phase = PH_ID;
                            else
                                r.length_rejected = 1'b1;
                        end
                        else
                            hdr_count++;
                    end
                    PH_ID:
                    begin
                        id_byte = it.rx_byte;
                        wr_pos  = 9'd1;
                        if (len_word == 1)
                            rx_phase = PH_HELD;
                        else
                            rx_phase = PH_PAYLOAD;
                    end
                    PH_PAYLOAD:
                    begin
                        if (wr_pos < MAX_FRAME_LEN)
                        begin
                            frame_buf[wr_pos] = it.rx_byte;
                            if (!buf_written[wr_pos])
                                written_idx.push_back(int'(wr_pos));
                            buf_written[wr_pos] = 1'b1;
                        end
                        wr_pos++;
                        if (wr_pos >= len_word)
                            rx_phase = PH_HELD;
                    end
                    default:
                        r.byte_taken = 1'b0;
                endcase
            end
            MODE_TICK:
            begin
                if (rx_phase != PH_HELD && tick_count != 16'hFFFF)
                    tick_count++;
            end
            MODE_RELEASE:
            begin
                rx_phase   = PH_LENGTH;
                hdr_count  = '0;
                tick_count = '0;
            end
            default:
                r.read_data = frame_buf[it.read_index];
        endcase
        if (rx_phase == PH_HELD)
            tick_count = '0;
        r.frame_ready  = (rx_phase == PH_HELD);
        r.frame_id     = (rx_phase == PH_PAYLOAD || rx_phase == PH_HELD) ? id_byte : 8'd0;
        r.frame_length = (rx_phase != PH_LENGTH) ? len_word[LEN_W-1:0] : '0;
        return r;
    endfunction

    function automatic plan_row_t row(mode_t m, logic [7:0] b, logic [7:0] idx,
                                      bit has_exp = 1'b0, out_item_t exp = '0);
        plan_row_t p;
        p.is_cfg     = 1'b0;
        p.cfg_value  = '0;
        p.item.mode       = m;
        p.item.rx_byte    = b;
        p.item.read_index = idx;
        p.has_exp    = has_exp;
        p.exp        = exp;
        return p;
    endfunction

    function automatic plan_row_t cfg_row(logic [15:0] v);
        plan_row_t p;
        p = row(MODE_TICK, 8'd0, 8'd0);
        p.is_cfg    = 1'b1;
        p.cfg_value = v;
        return p;
    endfunction

    // unused fields carry random bits so every input bit toggles
    function automatic in_item_t mk(mode_t m, logic [7:0] b);
        in_item_t it;
        it.mode       = m;
        it.rx_byte    = (m == MODE_BYTE) ? b : 8'($urandom);
        it.read_index = 8'($urandom);
        return it;
    endfunction

    // reads only ever target entries that have been written
    function automatic in_item_t aim_read(in_item_t it);
        in_item_t r;
        r = it;
        if (r.mode == MODE_READ)
        begin
            if (wr_pos > 9'd1 && $urandom_range(1) == 1)
                r.read_index = 8'($urandom_range(1, int'(wr_pos) - 1));
            else
                r.read_index = 8'(written_idx[$urandom_range(written_idx.size() - 1)]);
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("result item with nothing pending");
                mismatch_count++;
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("byte_taken", 32'(want.byte_taken),
                            32'(out_item.byte_taken));
                check_field("frame_ready", 32'(want.frame_ready),
                            32'(out_item.frame_ready));
                check_field("frame_id", 32'(want.frame_id), 32'(out_item.frame_id));
                check_field("frame_length", 32'(want.frame_length),
                            32'(out_item.frame_length));
                check_field("read_data", 32'(want.read_data), 32'(out_item.read_data));
                check_field("length_rejected", 32'(want.length_rejected),
                            32'(out_item.length_rejected));
                check_field("timed_out", 32'(want.timed_out), 32'(out_item.timed_out));
            end
        end
    end

    task automatic send_item(input in_item_t it, input bit use_exp = 1'b0,
                             input out_item_t exp = '0);
        out_item_t p;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        do
            @(posedge clk);
        while (in_stall);
        p = advance_receiver(it);
        predicted_results.push_back(use_exp ? exp : p);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        limit_reg = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_idling(input int sel);
        case (sel % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 58; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 58; end
            default: begin idle_pct = 31; stall_pct = 31; end
        endcase
    endtask

    task automatic push_header(input logic [31:0] v);
        for (int k = 3; k >= 0; k--)
            burst_q.push_back(mk(MODE_BYTE, v[8*k +: 8]));
    endtask

    task automatic build_burst();
        int          kind;
        int          len;
        int          cut;
        logic [31:0] bad;
        kind = $urandom_range(99);
        if (kind < 60)
        begin
            // well-formed frame with random content
            if ($urandom_range(99) < 80)
                burst_q.push_back(mk(MODE_RELEASE, 8'd0));
            if ($urandom_range(99) < 4)
                len = MAX_FRAME_LEN;
            else if ($urandom_range(99) < 8)
                len = $urandom_range(1, MAX_FRAME_LEN);
            else
                len = $urandom_range(1, 16);
            push_header(32'(len));
            burst_q.push_back(mk(MODE_BYTE, 8'($urandom)));
            for (int i = 1; i < len; i++)
            begin
                if ($urandom_range(99) < 8)
                    burst_q.push_back(mk(MODE_TICK, 8'd0));
                burst_q.push_back(mk(MODE_BYTE, 8'($urandom)));
            end
            repeat ($urandom_range(1, 3)) burst_q.push_back(mk(MODE_READ, 8'd0));
            if ($urandom_range(1) == 1)
                burst_q.push_back(mk(MODE_BYTE, 8'($urandom)));
            if ($urandom_range(99) < 70)
                burst_q.push_back(mk(MODE_RELEASE, 8'd0));
        end
        else if (kind < 72)
        begin
            // header that must be refused
            burst_q.push_back(mk(MODE_RELEASE, 8'd0));
            bad = $urandom();
            if ($urandom_range(1) == 1 || (bad >= 1 && bad <= MAX_FRAME_LEN))
                bad = ($urandom_range(1) == 1) ? 32'd0 : 32'(MAX_FRAME_LEN + 1);
            push_header(bad);
        end
        else if (kind < 84)
        begin
            // frame cut short, then left to age
            burst_q.push_back(mk(MODE_RELEASE, 8'd0));
            len = $urandom_range(2, 20);
            push_header(32'(len));
            cut = $urandom_range(0, len - 1);
            for (int i = 0; i < cut; i++)
                burst_q.push_back(mk(MODE_BYTE, 8'($urandom)));
            repeat ($urandom_range(0, 50)) burst_q.push_back(mk(MODE_TICK, 8'd0));
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                burst_q.push_back(mk(mode_t'($urandom_range(3)), 8'($urandom)));
        end
    endtask

    initial
    begin
        int sent;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        idle_pct   = 0;
        stall_pct  = 0;

        rx_phase   = PH_LENGTH;
        hdr_count  = '0;
        len_word   = '0;
        id_byte    = '0;
        wr_pos     = '0;
        tick_count = '0;
        limit_reg  = '0;
        foreach (frame_buf[i])
        begin
            frame_buf[i]   = '0;
            buf_written[i] = 1'b0;
        end

        directed_plan = '{
            row(MODE_TICK,    8'h00, 8'h00, 1'b1, OUT_QUIET),
            row(MODE_BYTE,    8'h00, 8'h00, 1'b1, OUT_TIMEOUT),
            row(MODE_BYTE,    8'h00, 8'h00, 1'b1, OUT_TAKEN),
            row(MODE_BYTE,    8'h00, 8'h00, 1'b1, OUT_TAKEN),
            row(MODE_BYTE,    8'h00, 8'h00, 1'b1, OUT_REJECTED),   // zero length
            cfg_row(16'hFFFF),
            row(MODE_BYTE,    8'h00, 8'h00),
            row(MODE_BYTE,    8'h00, 8'h00),
            row(MODE_BYTE,    8'h00, 8'h00),
            row(MODE_BYTE,    8'h01, 8'h00),
            row(MODE_BYTE,    8'hFF, 8'h00),                       // id only: held
            row(MODE_BYTE,    8'h55, 8'h00),                       // refused
            row(MODE_TICK,    8'h00, 8'h00),
            row(MODE_RELEASE, 8'h00, 8'h00),
            row(MODE_BYTE,    8'h00, 8'h00),
            row(MODE_BYTE,    8'h00, 8'h00),
            row(MODE_BYTE,    8'h01, 8'h00),
            row(MODE_BYTE,    8'h01, 8'h00, 1'b1, OUT_REJECTED),   // one past the max
            row(MODE_BYTE,    8'h00, 8'h00),
            row(MODE_BYTE,    8'h00, 8'h00),
            row(MODE_BYTE,    8'h00, 8'h00),
            row(MODE_BYTE,    8'h03, 8'h00),
            row(MODE_BYTE,    8'hAA, 8'h00),
            row(MODE_BYTE,    8'h01, 8'h00),
            row(MODE_BYTE,    8'hFE, 8'h00),
            row(MODE_READ,    8'h00, 8'h02)
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_cfg)
            begin
                drain();
                write_timeout(directed_plan[i].cfg_value);
            end
            else
                send_item(directed_plan[i].item, directed_plan[i].has_exp,
                          directed_plan[i].exp);
        end

        phase_limits[0] = 16'hFFFF;
        phase_limits[1] = 16'd40;
        phase_limits[2] = 16'd0;
        phase_limits[3] = 16'd7;
        phase_limits[4] = 16'($urandom_range(1, 200));
        phase_limits[5] = 16'd1;

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            write_timeout(phase_limits[p]);
            set_idling(p);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                build_burst();
                while (burst_q.size() != 0)
                begin
                    send_item(aim_read(burst_q.pop_front()));
                    sent++;
                end
            end
        end

        drain();
        if (mismatch_count == 0)
            $display("length_prefixed_frame_receiver_tb: clean");
        else
            $display("length_prefixed_frame_receiver_tb: errors");
        $finish;
    end

endmodule
